>>> design/rdwq_pkg.sv
package rdwq_pkg;

  localparam int ARRAY_DEPTH = 1024;
  localparam int VALUE_RANGE = 1024;

  localparam int POS_W  = 11;
  localparam int VAL_W  = 10;
  localparam int CNT_W  = 11;
  localparam int EADDR_W = $clog2(ARRAY_DEPTH);
  localparam int VADDR_W = $clog2(VALUE_RANGE);

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_QUERY = 2'd1,
    K_BAD   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   val;
    logic [POS_W-1:0]   left;
    logic [POS_W-1:0]   right;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

>>> design/rdwq_ram.sv
module rdwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> design/rdwq_front.sv
module rdwq_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rdwq_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  output rdwq_pkg::q_head_t              q_head,
  input  logic                           q_pop
);

  rdwq_pkg::item_t            mem_r [rdwq_pkg::QDEPTH];
  logic [rdwq_pkg::QPTR_W-1:0] wptr_r, rptr_r;
  logic [rdwq_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  logic [rdwq_pkg::POS_W-1:0] pos, left, right;
  logic [rdwq_pkg::VAL_W-1:0] val;
  logic                       load_ok, query_ok, push, pop;
  rdwq_pkg::item_t            item;

  assign pos   = in_tdata[10:0];
  assign val   = in_tdata[20:11];
  assign left  = in_tdata[31:21];
  assign right = in_tdata[42:32];

  always_comb begin
    load_ok  = (pos != '0) && (int'(pos) <= rdwq_pkg::ARRAY_DEPTH) &&
               (int'(val) < rdwq_pkg::VALUE_RANGE);
    query_ok = (left != '0) && (left <= right) && (int'(right) <= rdwq_pkg::ARRAY_DEPTH);
    item.pos   = pos;
    item.val   = val;
    item.left  = left;
    item.right = right;
    if (!in_tuser) begin
      item.kind = rdwq_pkg::K_LOAD;
    end else if (query_ok) begin
      item.kind = rdwq_pkg::K_QUERY;
    end else begin
      item.kind = rdwq_pkg::K_BAD;
    end
  end

  // out-of-range loads are taken and dropped here
  assign in_tready = (cnt_r != (rdwq_pkg::QPTR_W+1)'(rdwq_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready && (in_tuser || load_ok);
  assign pop       = q_pop && (cnt_r != '0);

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= item;
    end
  end

endmodule

>>> design/rdwq_back.sv
module rdwq_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rdwq_pkg::q_head_t               q_head,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rdwq_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser
);

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_WALK = 6'b000100,
    ST_ELEM = 6'b001000,
    ST_OCC  = 6'b010000,
    ST_LNEW = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  rdwq_pkg::item_t cur_r, cur_nxt;
  logic [rdwq_pkg::POS_W-1:0]   start_r, start_nxt, end_r, end_nxt;
  logic [rdwq_pkg::CNT_W-1:0]   dist_r, dist_nxt;
  logic [rdwq_pkg::VADDR_W-1:0] clr_r, clr_nxt;
  logic [rdwq_pkg::VAL_W-1:0]   val_r, val_nxt;
  logic dir_in_r, dir_in_nxt, phase_r, phase_nxt;
  logic out_valid_r, out_valid_nxt, out_all_r, out_all_nxt, out_bad_r, out_bad_nxt;
  logic [rdwq_pkg::CNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic                         e_we;
  logic [rdwq_pkg::EADDR_W-1:0] e_waddr, e_raddr;
  logic [rdwq_pkg::VAL_W-1:0]   e_wdata, e_rdata;
  logic                         o_we;
  logic [rdwq_pkg::VADDR_W-1:0] o_waddr, o_raddr;
  logic [rdwq_pkg::CNT_W-1:0]   o_wdata, o_rdata;

  logic                         out_free, in_win;
  logic [rdwq_pkg::POS_W-1:0]   pos_m1, start_m1, start_m2, end_m1, cur_pos_m1, len;

  rdwq_ram #(.WIDTH(rdwq_pkg::VAL_W), .DEPTH(rdwq_pkg::ARRAY_DEPTH)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  rdwq_ram #(.WIDTH(rdwq_pkg::CNT_W), .DEPTH(rdwq_pkg::VALUE_RANGE)) u_occ (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  assign out_free   = !out_valid_r || out_tready;
  assign pos_m1     = q_head.item.pos - 1'b1;
  assign cur_pos_m1 = cur_r.pos - 1'b1;
  assign start_m1   = start_r - 1'b1;
  assign start_m2   = start_r - 2'd2;
  assign end_m1     = end_r - 1'b1;
  assign in_win     = (q_head.item.pos >= start_r) && (q_head.item.pos <= end_r);
  assign len        = cur_r.right - cur_r.left + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    dist_nxt      = dist_r;
    clr_nxt       = clr_r;
    val_nxt       = val_r;
    dir_in_nxt    = dir_in_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_all_nxt   = out_all_r;
    out_cnt_nxt   = out_cnt_r;
    out_bad_nxt   = out_bad_r;
    q_pop         = 1'b0;
    e_we          = 1'b0;
    e_waddr       = pos_m1[rdwq_pkg::EADDR_W-1:0];
    e_wdata       = q_head.item.val;
    e_raddr       = pos_m1[rdwq_pkg::EADDR_W-1:0];
    o_we          = 1'b0;
    o_waddr       = val_r;
    o_wdata       = '0;
    o_raddr       = e_rdata;

    unique case (state_r)
      ST_CLR: begin
        o_we    = 1'b1;
        o_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == rdwq_pkg::VADDR_W'(rdwq_pkg::VALUE_RANGE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_head.valid) begin
          unique case (q_head.item.kind)
            rdwq_pkg::K_LOAD: begin
              q_pop   = 1'b1;
              cur_nxt = q_head.item;
              if (in_win) begin
                dir_in_nxt = 1'b0;
                phase_nxt  = 1'b0;
                state_nxt  = ST_ELEM;
              end else begin
                e_we = 1'b1;
              end
            end
            rdwq_pkg::K_QUERY: begin
              q_pop     = 1'b1;
              cur_nxt   = q_head.item;
              state_nxt = ST_WALK;
            end
            default: begin
              if (out_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_all_nxt   = 1'b0;
                out_cnt_nxt   = '0;
                out_bad_nxt   = 1'b1;
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        if (start_r > cur_r.left) begin
          e_raddr    = start_m2[rdwq_pkg::EADDR_W-1:0];
          start_nxt  = start_m1;
          dir_in_nxt = 1'b1;
          state_nxt  = ST_ELEM;
        end else if (end_r < cur_r.right) begin
          e_raddr    = end_r[rdwq_pkg::EADDR_W-1:0];
          end_nxt    = end_r + 1'b1;
          dir_in_nxt = 1'b1;
          state_nxt  = ST_ELEM;
        end else if (start_r < cur_r.left) begin
          e_raddr    = start_m1[rdwq_pkg::EADDR_W-1:0];
          start_nxt  = start_r + 1'b1;
          dir_in_nxt = 1'b0;
          state_nxt  = ST_ELEM;
        end else if (end_r > cur_r.right) begin
          e_raddr    = end_m1[rdwq_pkg::EADDR_W-1:0];
          end_nxt    = end_m1;
          dir_in_nxt = 1'b0;
          state_nxt  = ST_ELEM;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_all_nxt   = (dist_r == len);
          out_cnt_nxt   = dist_r;
          out_bad_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_ELEM: begin
        o_raddr   = e_rdata;
        val_nxt   = e_rdata;
        state_nxt = ST_OCC;
      end
      ST_OCC: begin
        if (dir_in_r) begin
          o_we    = 1'b1;
          o_wdata = o_rdata + 1'b1;
          if (o_rdata == '0) begin
            dist_nxt = dist_r + 1'b1;
          end
        end else if (o_rdata != '0) begin
          o_we    = 1'b1;
          o_wdata = o_rdata - 1'b1;
          if (o_rdata == rdwq_pkg::CNT_W'(1)) begin
            dist_nxt = dist_r - 1'b1;
          end
        end
        if (cur_r.kind == rdwq_pkg::K_LOAD) begin
          state_nxt = phase_r ? ST_IDLE : ST_LNEW;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_LNEW: begin
        // old value is out; count the new one in and store it
        o_raddr    = cur_r.val;
        val_nxt    = cur_r.val;
        dir_in_nxt = 1'b1;
        phase_nxt  = 1'b1;
        e_we       = 1'b1;
        e_waddr    = cur_pos_m1[rdwq_pkg::EADDR_W-1:0];
        e_wdata    = cur_r.val;
        state_nxt  = ST_OCC;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      start_r     <= rdwq_pkg::POS_W'(1);
      end_r       <= '0;
      dist_r      <= '0;
      dir_in_r    <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      dist_r      <= dist_nxt;
      dir_in_r    <= dir_in_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    val_r     <= val_nxt;
    out_all_r <= out_all_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rdwq_pkg::OUT_DATA_W - rdwq_pkg::CNT_W - 1){1'b0}}, out_cnt_r, out_all_r};
  assign out_tuser  = out_bad_r;

endmodule

>>> design/range_distinct_window_query.sv
// Flow: a load outside the window is written from idle; a load inside it counts the
// old value out, stores the new one and counts it in; a bad range answers from idle;
// a query steps the window a position at a time, then answers. One item at a time in
// the back end; each window step is an element read, a count read and a count write
// through the two simple dual-port RAMs. Reset: synchronous, active low; then a pass
// zeroes all 1024 count entries; beats still enter the queue but are not processed.
module range_distinct_window_query (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // position[10:0], element_value[20:11], range_left[31:21], range_right[42:32]
  input  logic [rdwq_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // all_distinct[0], distinct_count[11:1]
  output logic [rdwq_pkg::OUT_DATA_W-1:0] out_tdata,
  // bad_range
  output logic                            out_tuser
);

  rdwq_pkg::q_head_t q_head;
  logic              q_pop;

  rdwq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  rdwq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> sim/tb.sv
package rdwq_tb_pkg;
  import rdwq_pkg::*;

  localparam bit OP_LOAD  = 1'b0;
  localparam bit OP_QUERY = 1'b1;

  typedef struct {
    bit             all_distinct;
    bit [CNT_W-1:0] distinct_count;
    bit             bad_range;
  } answer_t;

  class distinct_window_scoreboard;
    answer_t        answers_due[$];
    bit [VAL_W-1:0] elem_mem [1:ARRAY_DEPTH];
    int unsigned    occ [VALUE_RANGE];
    int unsigned    wstart;
    int unsigned    wend;
    int unsigned    distinct_total;
    int unsigned    mismatches;

    function new();
      foreach (elem_mem[i]) elem_mem[i] = '0;
      foreach (occ[i]) occ[i] = 0;
      wstart = 1;
      wend = 0;
      distinct_total = 0;
      mismatches = 0;
    endfunction

    function void add_value(int unsigned v);
      occ[v]++;
      if (occ[v] == 1) distinct_total++;
    endfunction

    function void drop_value(int unsigned v);
      if (occ[v] == 0) return;
      occ[v]--;
      if (occ[v] == 0) distinct_total--;
    endfunction

    function int pending_answers();
      return answers_due.size();
    endfunction

    function void note_item(bit op, int unsigned pos, int unsigned val,
                            int unsigned l, int unsigned r);
      answer_t a;
      if (op == OP_LOAD) begin
        if (pos < 1 || pos > ARRAY_DEPTH) return;
        if (pos >= wstart && pos <= wend) begin
          drop_value(elem_mem[pos]);
          add_value(val);
        end
        elem_mem[pos] = val[VAL_W-1:0];
        return;
      end
      if (l < 1 || l > r || r > ARRAY_DEPTH) begin
        a.all_distinct = 1'b0;
        a.distinct_count = '0;
        a.bad_range = 1'b1;
        answers_due.push_back(a);
        return;
      end
      // grow to cover the new range, then shrink
      while (wstart > l) begin
        wstart--;
        add_value(elem_mem[wstart]);
      end
      while (wend < r) begin
        wend++;
        add_value(elem_mem[wend]);
      end
      while (wstart < l) begin
        drop_value(elem_mem[wstart]);
        wstart++;
      end
      while (wend > r) begin
        drop_value(elem_mem[wend]);
        wend--;
      end
      a.all_distinct = (distinct_total == r - l + 1);
      a.distinct_count = distinct_total[CNT_W-1:0];
      a.bad_range = 1'b0;
      answers_due.push_back(a);
    endfunction

    function void check_answer(bit all_distinct, bit [CNT_W-1:0] distinct_count,
                               bit bad_range);
      answer_t a;
      if (answers_due.size() == 0) begin
        $error("result beat with no query outstanding");
        mismatches++;
        return;
      end
      a = answers_due.pop_front();
      if (all_distinct != a.all_distinct) begin
        $error("all_distinct: expected %0d, got %0d", a.all_distinct, all_distinct);
        mismatches++;
      end
      if (distinct_count != a.distinct_count) begin
        $error("distinct_count: expected %0d, got %0d", a.distinct_count, distinct_count);
        mismatches++;
      end
      if (bad_range != a.bad_range) begin
        $error("bad_range: expected %0d, got %0d", a.bad_range, bad_range);
        mismatches++;
      end
    endfunction
  endclass

endpackage

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdwq_pkg::*;
  import rdwq_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 600;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  distinct_window_scoreboard sb = new();

  bit written [1:ARRAY_DEPTH];
  int prefix = 0;
  int items = 0;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  range_distinct_window_query uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_answer(out_tdata[0], out_tdata[CNT_W:1], out_tuser);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result-side backpressure
  initial begin
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12)) @(posedge clk);
    end
  end

  task automatic send_item(bit op, int unsigned pos, int unsigned val,
                           int unsigned l, int unsigned r);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[10:0]  = pos[10:0];
    d[20:11] = val[9:0];
    d[31:21] = l[10:0];
    d[42:32] = r[10:0];
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, pos[10:0], val[9:0], l[10:0], r[10:0]);
    items++;
    if (op == OP_LOAD && pos >= 1 && pos <= ARRAY_DEPTH) begin
      written[pos] = 1'b1;
      while (prefix < ARRAY_DEPTH && written[prefix + 1]) prefix++;
    end
  endtask

  task automatic load_elem(int unsigned pos, int unsigned val);
    send_item(OP_LOAD, pos, val, $urandom_range(0, 2047), $urandom_range(0, 2047));
  endtask

  task automatic ask_range(int unsigned l, int unsigned r);
    send_item(OP_QUERY, $urandom_range(0, 2047), $urandom_range(0, 1023), l, r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_answers() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic int unsigned pick_value();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 31);
    return $urandom_range(0, 1023);
  endfunction

  // ranges stay inside the written prefix, so the window never reads an unwritten element
  task automatic random_good_query();
    int lo;
    int hi;
    int t;
    if ($urandom_range(0, 9) < 6) begin
      lo = int'(sb.wstart) + int'($urandom_range(0, 16)) - 8;
      hi = int'(sb.wend) + int'($urandom_range(0, 16)) - 8;
    end else begin
      lo = $urandom_range(1, prefix);
      hi = $urandom_range(1, prefix);
    end
    if (lo < 1) lo = 1;
    if (lo > prefix) lo = prefix;
    if (hi < 1) hi = 1;
    if (hi > prefix) hi = prefix;
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    ask_range(lo, hi);
  endtask

  task automatic random_bad_query();
    int unsigned l;
    int unsigned r;
    case ($urandom_range(0, 2))
      0: begin
        l = 0;
        r = $urandom_range(0, 2047);
      end
      1: begin
        r = $urandom_range(1, 1023);
        l = $urandom_range(r + 1, 2047);
      end
      default: begin
        r = $urandom_range(ARRAY_DEPTH + 1, 2047);
        l = $urandom_range(1, r);
      end
    endcase
    ask_range(l, r);
  endtask

  initial begin
    int unsigned sel;
    bit paused;
    paused = 1'b0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    load_elem(1, 0);
    load_elem(2, 1023);
    load_elem(3, 0);
    load_elem(4, 1023);
    load_elem(5, 512);
    load_elem(0, 77);
    load_elem(ARRAY_DEPTH + 1, 3);
    load_elem(2047, 1023);
    ask_range(1, 1);
    ask_range(1, 5);
    ask_range(2, 2);
    ask_range(1, 3);
    load_elem(2, 0);
    ask_range(1, 3);
    ask_range(0, 0);
    ask_range(0, 5);
    ask_range(4, 3);
    ask_range(1, ARRAY_DEPTH + 1);
    ask_range(2047, 2047);
    ask_range(1, 2047);
    load_elem(ARRAY_DEPTH, 1023);
    ask_range(3, 5);
    drain();

    // random
    while (items < RANDOM_ITEMS) begin
      if (!paused && items >= RANDOM_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      quiet = (items >= RANDOM_ITEMS - 80);
      sel = $urandom_range(0, 99);
      if (sel < 35 && prefix < ARRAY_DEPTH)
        load_elem(prefix + 1, pick_value());
      else if (sel < 45 && sb.wend >= sb.wstart)
        load_elem($urandom_range(sb.wstart, sb.wend), pick_value());
      else if (sel < 50)
        load_elem($urandom_range(0, 2047), pick_value());
      else if (sel < 60)
        random_bad_query();
      else if (prefix >= 1)
        random_good_query();
      else
        load_elem(1, pick_value());
    end

    // queries within the written prefix, with two loads in between
    quiet = 1'b1;
    ask_range(1, prefix);
    ask_range(prefix, prefix);
    ask_range(1, prefix - 1);
    ask_range(prefix / 2, prefix);
    load_elem(ARRAY_DEPTH, 1023);
    load_elem(prefix, 0);
    ask_range(prefix / 2, prefix);
    ask_range(1, prefix);
    ask_range(1, 1);

    drain();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_answers() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
